### rtl/kbd_pkg.sv
// ----------------------------------------------------------------------------
// kbd_pkg
// Shared types, constants and tables for the key container deframer.
// ----------------------------------------------------------------------------
package kbd_pkg;

  // Result kinds carried on the output tuser.
  localparam logic [1:0] KIND_ID  = 2'd0;
  localparam logic [1:0] KIND_PAY = 2'd1;
  localparam logic [1:0] KIND_SUM = 2'd2;

  localparam int DATA_W    = 8;
  localparam int OUT_W     = 200;
  localparam int HASH_W    = 256;
  localparam int BLOCK_W   = 512;
  localparam int DIG_BYTES = 32;

  // Header register select.
  typedef enum logic [2:0] {
    HS_NONE, HS_VER, HS_ALG, HS_PUR, HS_FLG, HS_CRT, HS_IDL, HS_PLEN
  } hdr_sel_t;

  // Padding byte select.
  typedef enum logic [1:0] {
    PS_80, PS_00, PS_LEN
  } pad_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       absorb;
    logic       pad_wr;
    pad_sel_t   pad_sel;
    logic [2:0] len_idx;
    logic       asm_shift;
    hdr_sel_t   hdr_sel;
    logic       clr_field;
    logic       inc_off;
    logic       sha_start;
    logic       clear_all;
    logic       out_pass;
    logic [1:0] out_kind;
    logic       out_sum;
    logic       sum_ok;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       magic_ok;
    logic       dig_ok;
    logic       id_end;
    logic       pay_end;
    logic       plen_zero;
    logic [5:0] pos;
    logic [4:0] off_lo;
    logic       sha_done;
    logic       out_busy;
  } dp_status_t;

  localparam logic [HASH_W-1:0] SHA_IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = 8'h41;
      3'd1:    r = 8'h43;
      3'd2:    r = 8'h52;
      3'd3:    r = 8'h59;
      3'd4:    r = 8'h50;
      3'd5:    r = 8'h54;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] r;
    case (i)
      6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491; 6'd2:  r = 32'hb5c0fbcf;
      6'd3:  r = 32'he9b5dba5; 6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
      6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5; 6'd8:  r = 32'hd807aa98;
      6'd9:  r = 32'h12835b01; 6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe; 6'd14: r = 32'h9bdc06a7;
      6'd15: r = 32'hc19bf174; 6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc; 6'd20: r = 32'h2de92c6f;
      6'd21: r = 32'h4a7484aa; 6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d; 6'd26: r = 32'hb00327c8;
      6'd27: r = 32'hbf597fc7; 6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27b70a85;
      6'd33: r = 32'h2e1b2138; 6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb; 6'd38: r = 32'h81c2c92e;
      6'd39: r = 32'h92722c85; 6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3; 6'd44: r = 32'hd192e819;
      6'd45: r = 32'hd6990624; 6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08; 6'd50: r = 32'h2748774c;
      6'd51: r = 32'h34b0bcb5; 6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3; 6'd56: r = 32'h748f82ee;
      6'd57: r = 32'h78a5636f; 6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb; 6'd62: r = 32'hbef9a3f7;
      default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

endpackage

### rtl/kbd_sha_core.sv
// ----------------------------------------------------------------------------
// kbd_sha_core
// SHA-256 block buffer and compression unit, one round per cycle.
// ----------------------------------------------------------------------------
module kbd_sha_core
  import kbd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              init,
  input  logic              wr_en,
  input  logic [7:0]        wr_byte,
  input  logic              start,
  output logic              done,
  output logic [HASH_W-1:0] hash
);

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  logic [BLOCK_W-1:0] blk;
  logic [31:0]        a, b, c, d, e, f, g, h;
  logic [5:0]         rnd;
  logic               busy;
  logic               fin;
  logic [31:0]        w0, w1, w9, w14, s0, s1, w_new, t1, t2;

  // Message schedule from the sliding window of sixteen words.
  assign w0    = blk[511:480];
  assign w1    = blk[479:448];
  assign w9    = blk[223:192];
  assign w14   = blk[63:32];
  assign s0    = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
  assign s1    = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
  assign w_new = w0 + s0 + w9 + s1;

  // One compression round.
  assign t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
            + round_k(rnd) + w0;
  assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));

  always_ff @(posedge clk) begin
    if (rst || init) begin
      hash <= SHA_IV;
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      rnd  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        {a, b, c, d, e, f, g, h} <= hash;
        busy <= 1'b1;
        rnd  <= '0;
      end else if (busy) begin
        {a, b, c, d, e, f, g, h} <= {t1 + t2, a, b, c, d + t1, e, f, g};
        blk  <= {blk[BLOCK_W-33:0], w_new};
        rnd  <= rnd + 6'd1;
        if (rnd == 6'd63) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        hash <= {hash[255:224] + a, hash[223:192] + b, hash[191:160] + c,
                 hash[159:128] + d, hash[127:96] + e, hash[95:64] + f,
                 hash[63:32] + g, hash[31:0] + h};
        fin  <= 1'b0;
        done <= 1'b1;
      end else if (wr_en) begin
        blk <= {blk[BLOCK_W-9:0], wr_byte};
      end
    end
  end

endmodule

### rtl/kbd_dp.sv
// ----------------------------------------------------------------------------
// kbd_dp
// Datapath: field assembly, header registers, counters, hash unit and the
// output register.
// ----------------------------------------------------------------------------
module kbd_dp
  import kbd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  dp_cmd_t          cmd,
  input  logic [7:0]       in_byte,
  output dp_status_t       st,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_kind,
  output logic [OUT_W-1:0] out_data
);

  logic [31:0]  off;
  logic [63:0]  asm_sr;
  logic [63:0]  asm_new;
  logic [15:0]  hdr_version, hdr_algorithm, hdr_purpose;
  logic [31:0]  hdr_flags, hdr_payload_length;
  logic [63:0]  hdr_created;
  logic [7:0]   hdr_id_length;
  logic [60:0]  byte_cnt;
  logic [63:0]  bit_cnt;
  logic [5:0]   pos;
  logic [HASH_W-1:0] hash;
  logic         sha_done;
  logic [7:0]   pad_byte, wr_byte, want;
  logic [31:0]  off_inc;
  logic [OUT_W-1:0] sum_data;

  assign asm_new = {asm_sr[55:0], in_byte};
  assign bit_cnt = {byte_cnt, 3'b000};
  assign off_inc = off + 32'd1;
  assign want    = hash[HASH_W-1 - 8*off[4:0] -: 8];

  // Padding byte: marker, zero fill or big-endian length.
  always_comb begin
    case (cmd.pad_sel)
      PS_80:   pad_byte = 8'h80;
      PS_00:   pad_byte = 8'h00;
      default: pad_byte = bit_cnt[63 - 8*cmd.len_idx -: 8];
    endcase
  end
  assign wr_byte = cmd.pad_wr ? pad_byte : in_byte;

  kbd_sha_core u_sha (
    .clk     (clk),
    .rst     (rst),
    .init    (cmd.clear_all),
    .wr_en   (cmd.absorb || cmd.pad_wr),
    .wr_byte (wr_byte),
    .start   (cmd.sha_start),
    .done    (sha_done),
    .hash    (hash)
  );

  // Status toward the controller.
  always_comb begin
    st.magic_ok  = (in_byte == magic_byte(off[2:0]));
    st.dig_ok    = (in_byte == want);
    st.id_end    = (off_inc == {24'd0, hdr_id_length});
    st.pay_end   = (off_inc == hdr_payload_length);
    st.plen_zero = (asm_new[31:0] == 32'd0);
    st.pos       = pos;
    st.off_lo    = off[4:0];
    st.sha_done  = sha_done;
    st.out_busy  = out_valid && !out_ready;
  end

  // Field assembly, counters and header registers.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      off                <= '0;
      asm_sr             <= '0;
      hdr_version        <= '0;
      hdr_algorithm      <= '0;
      hdr_purpose        <= '0;
      hdr_flags          <= '0;
      hdr_created        <= '0;
      hdr_id_length      <= '0;
      hdr_payload_length <= '0;
      byte_cnt           <= '0;
      pos                <= '0;
    end else begin
      if (cmd.absorb) byte_cnt <= byte_cnt + 61'd1;
      if (cmd.absorb || cmd.pad_wr) pos <= pos + 6'd1;
      if (cmd.clr_field) begin
        off    <= '0;
        asm_sr <= '0;
      end else begin
        if (cmd.inc_off) off <= off_inc;
        if (cmd.asm_shift) asm_sr <= asm_new;
      end
      case (cmd.hdr_sel)
        HS_VER:  hdr_version        <= asm_new[15:0];
        HS_ALG:  hdr_algorithm      <= asm_new[15:0];
        HS_PUR:  hdr_purpose        <= asm_new[15:0];
        HS_FLG:  hdr_flags          <= asm_new[31:0];
        HS_CRT:  hdr_created        <= asm_new;
        HS_IDL:  hdr_id_length      <= asm_new[7:0];
        HS_PLEN: hdr_payload_length <= asm_new[31:0];
        default: ;
      endcase
    end
  end

  // Summary word; header fields are only reported for a valid container.
  always_comb begin
    sum_data      = '0;
    sum_data[8]   = !cmd.sum_ok;
    sum_data[193] = 1'b1;
    if (cmd.sum_ok) begin
      sum_data[24:9]    = hdr_version;
      sum_data[40:25]   = hdr_algorithm;
      sum_data[56:41]   = hdr_purpose;
      sum_data[88:57]   = hdr_flags;
      sum_data[152:89]  = hdr_created;
      sum_data[160:153] = hdr_id_length;
      sum_data[192:161] = hdr_payload_length;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_sum) begin
      out_valid <= 1'b1;
      out_kind  <= KIND_SUM;
      out_data  <= sum_data;
    end else if (cmd.out_pass) begin
      out_valid <= 1'b1;
      out_kind  <= cmd.out_kind;
      out_data  <= {{(OUT_W-8){1'b0}}, in_byte};
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### rtl/kbd_ctrl.sv
// ----------------------------------------------------------------------------
// kbd_ctrl
// Controller: container parse phases, padding sequence and hash block
// scheduling.
// ----------------------------------------------------------------------------
module kbd_ctrl
  import kbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);

  typedef enum logic [1:0] {S_IDLE, S_PAD, S_CSTART, S_CWAIT} seq_t;
  typedef enum logic [3:0] {
    PH_MAGIC, PH_VER, PH_ALG, PH_PUR, PH_FLG, PH_CRT, PH_IDL, PH_ID,
    PH_PLEN, PH_PAY, PH_DIG, PH_DONE, PH_DRAIN
  } phase_t;

  seq_t       seq, seq_next;
  phase_t     phase, phase_next;
  logic       err, err_next;
  logic       resume, resume_next;
  logic       pad_first, pad_first_next;
  logic       in_len, in_len_next;
  logic [2:0] len_idx, len_idx_next;
  logic       fire, fin, field_end, pad_final;
  logic [4:0] fld_last;

  assign in_ready = (seq == S_IDLE) && !st.out_busy;
  assign fire     = in_valid && in_ready;

  // Index of the final byte of each fixed-size field.
  always_comb begin
    case (phase)
      PH_MAGIC: fld_last = 5'd5;
      PH_VER, PH_ALG, PH_PUR: fld_last = 5'd1;
      PH_FLG, PH_PLEN: fld_last = 5'd3;
      PH_CRT:   fld_last = 5'd7;
      PH_DIG:   fld_last = 5'd31;
      default:  fld_last = 5'd0;
    endcase
  end
  assign field_end = (st.off_lo == fld_last);

  // Per-byte decisions and padding sequence.
  always_comb begin
    cmd            = '0;
    cmd.hdr_sel    = HS_NONE;
    cmd.pad_sel    = PS_80;
    cmd.len_idx    = len_idx;
    seq_next       = seq;
    phase_next     = phase;
    err_next       = err;
    resume_next    = resume;
    pad_first_next = pad_first;
    in_len_next    = in_len;
    len_idx_next   = len_idx;
    fin            = 1'b0;
    pad_final      = 1'b0;

    case (seq)
      S_IDLE: begin
        if (fire) begin
          case (phase)
            PH_MAGIC: begin
              if (!st.magic_ok) begin
                err_next = 1'b1; phase_next = PH_DRAIN; cmd.clr_field = 1'b1;
              end else begin
                cmd.absorb = 1'b1; cmd.inc_off = 1'b1;
                if (field_end) begin
                  phase_next = PH_VER; cmd.clr_field = 1'b1;
                end
              end
            end
            PH_VER, PH_ALG, PH_PUR, PH_FLG, PH_CRT, PH_IDL, PH_PLEN: begin
              cmd.absorb = 1'b1; cmd.asm_shift = 1'b1; cmd.inc_off = 1'b1;
              if (field_end) begin
                cmd.clr_field = 1'b1;
                case (phase)
                  PH_VER: begin cmd.hdr_sel = HS_VER; phase_next = PH_ALG; end
                  PH_ALG: begin cmd.hdr_sel = HS_ALG; phase_next = PH_PUR; end
                  PH_PUR: begin cmd.hdr_sel = HS_PUR; phase_next = PH_FLG; end
                  PH_FLG: begin cmd.hdr_sel = HS_FLG; phase_next = PH_CRT; end
                  PH_CRT: begin cmd.hdr_sel = HS_CRT; phase_next = PH_IDL; end
                  PH_IDL: begin
                    cmd.hdr_sel = HS_IDL;
                    phase_next  = (in_byte == 8'd0) ? PH_PLEN : PH_ID;
                  end
                  default: begin
                    cmd.hdr_sel = HS_PLEN;
                    if (st.plen_zero) begin
                      fin = 1'b1; phase_next = PH_DIG;
                    end else begin
                      phase_next = PH_PAY;
                    end
                  end
                endcase
              end
            end
            PH_ID, PH_PAY: begin
              cmd.absorb   = 1'b1; cmd.inc_off = 1'b1; cmd.out_pass = 1'b1;
              cmd.out_kind = (phase == PH_ID) ? KIND_ID : KIND_PAY;
              if (phase == PH_ID && st.id_end) begin
                phase_next = PH_PLEN; cmd.clr_field = 1'b1;
              end else if (phase == PH_PAY && st.pay_end) begin
                fin = 1'b1; phase_next = PH_DIG; cmd.clr_field = 1'b1;
              end
            end
            PH_DIG: begin
              if (!st.dig_ok) begin
                err_next = 1'b1; phase_next = PH_DRAIN; cmd.clr_field = 1'b1;
              end else begin
                cmd.inc_off = 1'b1;
                if (field_end) begin
                  phase_next = PH_DONE; cmd.clr_field = 1'b1;
                end
              end
            end
            PH_DONE: begin
              err_next = 1'b1; phase_next = PH_DRAIN;
            end
            default: ;
          endcase

          if (in_last) begin
            // Summary ends the container and returns everything to reset.
            cmd.out_pass  = 1'b0;
            cmd.out_sum   = 1'b1;
            cmd.sum_ok    = (phase_next == PH_DONE) && !err_next;
            cmd.clear_all = 1'b1;
            cmd.hdr_sel   = HS_NONE;
            cmd.absorb    = 1'b0;
            phase_next    = PH_MAGIC;
            err_next      = 1'b0;
          end else begin
            if (fin) begin
              pad_first_next = 1'b1;
              in_len_next    = 1'b0;
              len_idx_next   = '0;
            end
            if (cmd.absorb && st.pos == 6'd63) begin
              seq_next    = S_CSTART;
              resume_next = fin;
            end else if (fin) begin
              seq_next = S_PAD;
            end
          end
        end
      end
      S_PAD: begin
        cmd.pad_wr = 1'b1;
        if (pad_first) begin
          cmd.pad_sel = PS_80;
        end else if (!in_len && st.pos != 6'd56) begin
          cmd.pad_sel = PS_00;
        end else begin
          cmd.pad_sel = PS_LEN;
        end
        pad_first_next = 1'b0;
        if (cmd.pad_sel == PS_LEN) begin
          in_len_next  = 1'b1;
          len_idx_next = len_idx + 3'd1;
          pad_final    = (len_idx == 3'd7);
        end
        if (st.pos == 6'd63) begin
          seq_next    = S_CSTART;
          resume_next = !pad_final;
        end
      end
      S_CSTART: begin
        cmd.sha_start = 1'b1;
        seq_next      = S_CWAIT;
      end
      default: begin
        if (st.sha_done) seq_next = resume ? S_PAD : S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq       <= S_IDLE;
      phase     <= PH_MAGIC;
      err       <= 1'b0;
      resume    <= 1'b0;
      pad_first <= 1'b0;
      in_len    <= 1'b0;
      len_idx   <= '0;
    end else begin
      seq       <= seq_next;
      phase     <= phase_next;
      err       <= err_next;
      resume    <= resume_next;
      pad_first <= pad_first_next;
      in_len    <= in_len_next;
      len_idx   <= len_idx_next;
    end
  end

endmodule

### rtl/key_blob_deframer_sha256_check.sv
// Key container deframer with SHA-256 check. Header, id and payload bytes are
// taken one per cycle while the output register is not held by backpressure;
// each time 64 body bytes fill a hash block the input stalls while the single
// round-per-cycle SHA-256 unit compresses it, and after the last payload byte
// the padding and length bytes go in one per cycle with one or two further
// compressions before the digest bytes are taken. Id and payload bytes are
// passed on as they arrive; the final byte yields a single summary
// transaction.
// ----------------------------------------------------------------------------
// key_blob_deframer_sha256_check
// Top level: stream ports, controller and datapath.
// ----------------------------------------------------------------------------
module key_blob_deframer_sha256_check
  import kbd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,   // data_byte[7:0]
  input  logic             s_tlast,
  output logic             m_tvalid,
  input  logic             m_tready,
  // out_byte[7:0], status[8], version[24:9], algorithm[40:25],
  // purpose[56:41], key_flags[88:57], created_time[152:89],
  // id_length[160:153], payload_length[192:161], done_res[193], zero above
  output logic [OUT_W-1:0] m_tdata,
  output logic [1:0]       m_tuser    // kind[1:0]
);

  dp_cmd_t    cmd;
  dp_status_t st;

  kbd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .in_last  (s_tlast),
    .st       (st),
    .cmd      (cmd)
  );

  kbd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_byte   (s_tdata),
    .st        (st),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_kind  (m_tuser),
    .out_data  (m_tdata)
  );

endmodule

### tb/kbd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbd_checker
// Scoreboard for the key container deframer. A software SHA-256 lives in a
// small package so that the stimulus side can also seal valid containers.
// The checker follows every accepted input byte, predicts the pass-on and
// summary transactions and compares each output transaction field by field.
// ----------------------------------------------------------------------------
package tb_sha_pkg;

  typedef logic [7:0] byte_q_t[$];

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Full SHA-256 of a byte string, digest with the first byte in the top bits.
  function automatic logic [255:0] sha256_of(input byte_q_t msg);
    logic [31:0] h [8];
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, hh, t1, t2, s0, s1;
    logic [7:0]  m [$];
    logic [63:0] bits;
    int          blk;
    int          i;
    m = msg;
    bits = 64'(msg.size()) * 8;
    m = {m, 8'h80};
    while (m.size() % 64 != 56) m = {m, 8'h00};
    for (i = 0; i < 8; i++) m = {m, bits[63 - 8*i -: 8]};
    h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
          32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    for (blk = 0; blk < m.size(); blk += 64) begin
      for (i = 0; i < 16; i++)
        w[i] = {m[blk+4*i], m[blk+4*i+1], m[blk+4*i+2], m[blk+4*i+3]};
      for (i = 16; i < 64; i++) begin
        s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
        s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
        w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4]; f = h[5]; g = h[6]; hh = h[7];
      for (i = 0; i < 64; i++) begin
        t1 = hh + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
             + K_TAB[i] + w[i];
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        hh = g; g = f; f = e; e = d + t1;
        d = c; c = b; b = a; a = t1 + t2;
      end
      h[0] += a; h[1] += b; h[2] += c; h[3] += d;
      h[4] += e; h[5] += f; h[6] += g; h[7] += hh;
    end
    return {h[0], h[1], h[2], h[3], h[4], h[5], h[6], h[7]};
  endfunction

endpackage

module kbd_checker
  import kbd_pkg::*;
  import tb_sha_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [7:0]       s_tdata,
  input  logic             s_tlast,
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [OUT_W-1:0] m_tdata,
  input  logic [1:0]       m_tuser,
  output int               errors,
  output int               pending
);

  typedef enum logic [3:0] {
    P_MAGIC, P_VER, P_ALG, P_PUR, P_FLG, P_CRT, P_IDL, P_ID, P_PLEN, P_PAY,
    P_DIG, P_DONE, P_DRAIN
  } parse_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [OUT_W-1:0] data;
  } xact_t;

  localparam logic [7:0] MAGIC [6] = '{8'h41, 8'h43, 8'h52, 8'h59, 8'h50, 8'h54};

  xact_t       expected_q[$];
  parse_t      phase;
  int unsigned offset;
  logic [63:0] shreg;
  logic [15:0] f_ver, f_alg, f_pur;
  logic [31:0] f_flags, f_plen;
  logic [63:0] f_created;
  logic [7:0]  f_idl;
  logic        bad;
  byte_q_t     body;
  logic [255:0] digest;

  function automatic int field_bytes(input parse_t p);
    case (p)
      P_VER, P_ALG, P_PUR: return 2;
      P_FLG, P_PLEN:       return 4;
      P_CRT:               return 8;
      default:             return 1;
    endcase
  endfunction

  task automatic enter(input parse_t p);
    phase = p;
    offset = 0;
    shreg = '0;
  endtask

  task automatic clear_all();
    enter(P_MAGIC);
    f_ver = '0; f_alg = '0; f_pur = '0; f_flags = '0;
    f_created = '0; f_idl = '0; f_plen = '0;
    bad = 1'b0;
    body.delete();
  endtask

  task automatic latch_error();
    bad = 1'b1;
    enter(P_DRAIN);
  endtask

  task automatic seal_body();
    digest = sha256_of(body);
    enter(P_DIG);
  endtask

  // Advance the parser by one container byte and queue what it should yield.
  task automatic follow_byte(input logic [7:0] b, input logic lst);
    xact_t x;
    logic  emit;
    emit = 1'b0;
    x = '0;
    case (phase)
      P_MAGIC: begin
        if (b != MAGIC[offset]) latch_error();
        else begin
          body = {body, b};
          offset++;
          if (offset >= 6) enter(P_VER);
        end
      end
      P_VER, P_ALG, P_PUR, P_FLG, P_CRT, P_IDL, P_PLEN: begin
        body = {body, b};
        shreg = {shreg[55:0], b};
        offset++;
        if (offset >= field_bytes(phase)) begin
          case (phase)
            P_VER: begin f_ver = shreg[15:0]; enter(P_ALG); end
            P_ALG: begin f_alg = shreg[15:0]; enter(P_PUR); end
            P_PUR: begin f_pur = shreg[15:0]; enter(P_FLG); end
            P_FLG: begin f_flags = shreg[31:0]; enter(P_CRT); end
            P_CRT: begin f_created = shreg; enter(P_IDL); end
            P_IDL: begin
              f_idl = shreg[7:0];
              enter(f_idl == 0 ? P_PLEN : P_ID);
            end
            default: begin
              f_plen = shreg[31:0];
              if (f_plen == 0) seal_body();
              else enter(P_PAY);
            end
          endcase
        end
      end
      P_ID, P_PAY: begin
        body = {body, b};
        emit = 1'b1;
        x.kind = (phase == P_ID) ? KIND_ID : KIND_PAY;
        x.data[7:0] = b;
        offset++;
        if (phase == P_ID && offset >= f_idl) enter(P_PLEN);
        else if (phase == P_PAY && offset >= f_plen) seal_body();
      end
      P_DIG: begin
        if (digest[255 - 8*offset -: 8] != b) latch_error();
        else begin
          offset++;
          if (offset >= DIG_BYTES) enter(P_DONE);
        end
      end
      P_DONE: latch_error();
      default: ;
    endcase
    // The last byte replaces any pass-on with the summary.
    if (lst) begin
      x = '0;
      emit = 1'b1;
      x.kind = KIND_SUM;
      x.data[193] = 1'b1;
      if (phase == P_DONE && !bad) begin
        x.data[24:9] = f_ver;
        x.data[40:25] = f_alg;
        x.data[56:41] = f_pur;
        x.data[88:57] = f_flags;
        x.data[152:89] = f_created;
        x.data[160:153] = f_idl;
        x.data[192:161] = f_plen;
      end else begin
        x.data[8] = 1'b1;
      end
      clear_all();
    end
    if (emit) expected_q = {expected_q, x};
  endtask

  task automatic compare_field(input string nm, input logic [63:0] e, input logic [63:0] a);
    if (e !== a) begin
      errors++;
      $display("%0t: mismatch on %s, expected %h, got %h", $time, nm, e, a);
    end
  endtask

  always @(posedge clk) begin
    xact_t x;
    if (rst) begin
      errors = 0;
      clear_all();
    end else begin
      if (s_tvalid && s_tready) follow_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected transaction, expected none, got kind %0d data %h",
                   $time, m_tuser, m_tdata);
        end else begin
          x = expected_q.pop_front();
          compare_field("kind", x.kind, m_tuser);
          compare_field("out_byte", x.data[7:0], m_tdata[7:0]);
          compare_field("status", x.data[8], m_tdata[8]);
          compare_field("version", x.data[24:9], m_tdata[24:9]);
          compare_field("algorithm", x.data[40:25], m_tdata[40:25]);
          compare_field("purpose", x.data[56:41], m_tdata[56:41]);
          compare_field("key_flags", x.data[88:57], m_tdata[88:57]);
          compare_field("created_time", x.data[152:89], m_tdata[152:89]);
          compare_field("id_length", x.data[160:153], m_tdata[160:153]);
          compare_field("payload_length", x.data[192:161], m_tdata[192:161]);
          compare_field("done_res", x.data[193], m_tdata[193]);
          compare_field("pad bits", x.data[199:194], m_tdata[199:194]);
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

### tb/tb_key_blob_deframer_sha256_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_blob_deframer_sha256_check
// Feeds sealed key containers, intact and damaged, through the deframer
// with random gaps and backpressure; the checker module scores the outputs.
// ----------------------------------------------------------------------------
module tb_key_blob_deframer_sha256_check;
  import kbd_pkg::*;
  import tb_sha_pkg::*;

  typedef enum int {
    C_GOOD, C_BAD_MAGIC, C_BAD_DIGEST, C_TRUNCATED, C_TOO_LONG, C_NOISE
  } shape_t;

  localparam int ITEM_TARGET = 1100;

  logic             clk = 1'b0;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [7:0]       s_tdata;
  logic             s_tlast;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic [1:0]       m_tuser;
  int               errors;
  int               pending;
  int               items_sent = 0;
  int               send_idle_pct;
  int               recv_idle_pct;

  key_blob_deframer_sha256_check u_top (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser
  );

  kbd_checker u_chk (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .errors, .pending
  );

  always #5 clk = ~clk;

  // Idle rates move through three stretches of the run.
  always_comb begin
    if (items_sent < ITEM_TARGET / 3) begin
      send_idle_pct = 17; recv_idle_pct = 70;
    end else if (items_sent < 2 * ITEM_TARGET / 3) begin
      send_idle_pct = 70; recv_idle_pct = 17;
    end else begin
      send_idle_pct = 0; recv_idle_pct = 0;
    end
  end

  // Receiver backpressure.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // One input transaction, with an optional gap ahead of it.
  task automatic send_byte(input logic [7:0] b, input logic lst);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= lst;
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    items_sent++;
  endtask

  task automatic send_stream(input byte_q_t q);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  // Build a container of the given shape and send it.
  task automatic send_container(input shape_t shape);
    byte_q_t     q;
    logic [31:0] idl, plen, declared;
    logic [63:0] created;
    logic [255:0] dig;
    int          i, cut;
    q = '{8'h41, 8'h43, 8'h52, 8'h59, 8'h50, 8'h54};
    idl = ($urandom_range(9) == 0) ? 255 : $urandom_range(6);
    plen = ($urandom_range(7) == 0) ? $urandom_range(130, 60) : $urandom_range(30);
    created = {$urandom, $urandom};
    declared = (shape == C_TRUNCATED && $urandom_range(1)) ? $urandom : plen;
    for (i = 0; i < 6; i++) q = {q, 8'($urandom)};
    for (i = 0; i < 4; i++) q = {q, 8'($urandom)};
    for (i = 0; i < 8; i++) q = {q, created[63 - 8*i -: 8]};
    q = {q, idl[7:0]};
    for (i = 0; i < idl; i++) q = {q, 8'($urandom)};
    for (i = 0; i < 4; i++) q = {q, declared[31 - 8*i -: 8]};
    for (i = 0; i < plen; i++) q = {q, 8'($urandom)};
    dig = sha256_of(q);
    for (i = 0; i < 32; i++) q = {q, dig[255 - 8*i -: 8]};
    case (shape)
      C_BAD_MAGIC: q[$urandom_range(5)] ^= 8'(1 << $urandom_range(7));
      C_BAD_DIGEST: q[q.size() - 1 - $urandom_range(31)] ^= 8'(1 << $urandom_range(7));
      C_TRUNCATED: begin
        cut = $urandom_range(q.size() - 2, 1);
        while (q.size() > cut) q.pop_back();
      end
      C_TOO_LONG: repeat ($urandom_range(3, 1)) q = {q, 8'($urandom)};
      C_NOISE: begin
        q.delete();
        repeat ($urandom_range(20, 1)) q = {q, 8'($urandom)};
      end
      default: ;
    endcase
    send_stream(q);
  endtask

  // Stimulus.
  initial begin
    shape_t shape;
    int     pick;
    int     n_containers;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tlast <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Short directed streams: a single wrong byte, a single right byte, bare
    // magic, bad magic then ignored bytes, and magic with two more bytes.
    send_stream('{8'hff});
    send_stream('{8'h41});
    send_stream('{8'h41, 8'h43, 8'h52, 8'h59, 8'h50, 8'h54});
    send_stream('{8'h41, 8'h43, 8'h00, 8'h54, 8'hff, 8'h41});
    send_stream('{8'h41, 8'h43, 8'h52, 8'h59, 8'h50, 8'h54, 8'h12, 8'h34});

    n_containers = 0;
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(99);
      if (pick < 55) shape = C_GOOD;
      else if (pick < 64) shape = C_BAD_MAGIC;
      else if (pick < 73) shape = C_BAD_DIGEST;
      else if (pick < 85) shape = C_TRUNCATED;
      else if (pick < 93) shape = C_TOO_LONG;
      else shape = C_NOISE;
      send_container(shape);
      n_containers++;
      // Let the pipeline run dry once before going on.
      if (n_containers == 2) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
    end
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    if (errors == 0) begin
      $display("tb_key_blob_deframer_sha256_check: done, clean");
    end else begin
      $display("tb_key_blob_deframer_sha256_check: done, errors");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5_000_000;
    $display("tb_key_blob_deframer_sha256_check: done, errors");
    $finish;
  end

endmodule

### files.f
rtl/kbd_pkg.sv
rtl/kbd_sha_core.sv
rtl/kbd_dp.sv
rtl/kbd_ctrl.sv
rtl/key_blob_deframer_sha256_check.sv
tb/kbd_checker.sv
tb/tb_key_blob_deframer_sha256_check.sv
